// ----- src/alarm_frame_deframer_macros.svh -----
// assertion macros for the alarm frame deframer
// used by afd_parser, no other dependencies
`ifndef ALARM_FRAME_DEFRAMER_MACROS_SVH
`define ALARM_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, checked outside reset
`define AFD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define AFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/afd_pkg.sv -----
// shared constants and types for the alarm frame deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package afd_pkg;

   localparam int MAX_FRAME_DEFAULT = 1024;

   localparam logic [7:0]  START_FIRST = 8'h20;
   localparam logic [7:0]  CR_BYTE     = 8'h0D;
   localparam logic [15:0] END_PAIR    = 16'h0D0D;
   localparam logic [31:0] SMOKE_MARK  = 32'hBBF0BEAF;
   localparam logic [7:0]  ASCII_ZERO  = 8'h30;
   localparam logic [7:0]  ASCII_NINE  = 8'h39;

   localparam logic [1:0] KIND_NORMAL   = 2'd0;
   localparam logic [1:0] KIND_SMOKE    = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0] frame_kind;
      logic [9:0] point_number;
      logic       point_valid;
   } afd_result_type;

endpackage

`default_nettype wire

// ----- src/afd_parser.sv -----
// frame parser: hunting, byte history, smoke marker and point digits
// depends on afd_pkg and alarm_frame_deframer_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "alarm_frame_deframer_macros.svh"

module afd_parser #(
   parameter int MAX_FRAME = afd_pkg::MAX_FRAME_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic [7:0]              rx_byte,
   output logic                         emit,
   output afd_pkg::afd_result_type      result
);

   localparam int CW = $clog2(MAX_FRAME + 1);
   localparam logic [1:0] MODE_HUNT  = 2'd0;
   localparam logic [1:0] MODE_FRAME = 2'd1;

   logic [1:0]    mode_ff, mode_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   recent_ff, recent_in;
   logic          smoke_ff, smoke_in;
   logic [9:0]    accum_ff, accum_in;
   logic          bad_ff, bad_in;

   logic [31:0]   shifted;
   logic [CW-1:0] count_inc;
   logic          is_digit;
   logic          digit_slot;
   logic [3:0]    digit;
   logic          frame_end;
   logic          overflow;
   logic          valid_point;

   always_comb begin
      shifted     = {recent_ff[23:0], rx_byte};
      count_inc   = count_ff + CW'(1);
      is_digit    = (rx_byte >= afd_pkg::ASCII_ZERO) && (rx_byte <= afd_pkg::ASCII_NINE);
      digit_slot  = (count_ff >= CW'(2)) && (count_ff <= CW'(4));
      digit       = is_digit ? 4'(rx_byte - afd_pkg::ASCII_ZERO) : 4'd0;

      mode_in     = mode_ff;
      count_in    = count_ff;
      recent_in   = recent_ff;
      smoke_in    = smoke_ff;
      accum_in    = accum_ff;
      bad_in      = bad_ff;
      frame_end   = 1'b0;
      overflow    = 1'b0;
      valid_point = 1'b0;
      emit        = 1'b0;
      result      = '0;

      if (mode_ff != MODE_FRAME) begin
         if ((recent_ff[7:0] == afd_pkg::START_FIRST) && (rx_byte == afd_pkg::CR_BYTE)) begin
            mode_in   = MODE_FRAME;
            count_in  = CW'(2);
            recent_in = {16'h0000, afd_pkg::START_FIRST, afd_pkg::CR_BYTE};
            smoke_in  = 1'b0;
            accum_in  = '0;
            bad_in    = 1'b0;
         end else begin
            recent_in = shifted;
         end
      end else begin
         recent_in = shifted;
         if (digit_slot) begin
            // accum * 10 + digit, kept to 10 bits
            accum_in = {accum_ff[6:0], 3'b000} + {accum_ff[8:0], 1'b0} + {6'd0, digit};
            bad_in   = bad_ff | ~is_digit;
         end
         count_in = count_inc;
         if (shifted == afd_pkg::SMOKE_MARK) begin
            smoke_in = 1'b1;
         end
         frame_end   = (count_inc > CW'(2)) && (shifted[15:0] == afd_pkg::END_PAIR);
         overflow    = count_inc >= CW'(MAX_FRAME);
         valid_point = ~bad_in && (count_inc >= CW'(5));
         if (frame_end) begin
            emit                = step;
            result.frame_kind   = smoke_in ? afd_pkg::KIND_SMOKE : afd_pkg::KIND_NORMAL;
            result.point_number = valid_point ? accum_in : 10'd0;
            result.point_valid  = valid_point;
         end else if (overflow) begin
            emit              = step;
            result.frame_kind = afd_pkg::KIND_OVERFLOW;
         end
         if (frame_end || overflow) begin
            mode_in   = MODE_HUNT;
            count_in  = '0;
            recent_in = '0;
            smoke_in  = 1'b0;
            accum_in  = '0;
            bad_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_HUNT;
         count_ff  <= '0;
         recent_ff <= '0;
         smoke_ff  <= 1'b0;
         accum_ff  <= '0;
         bad_ff    <= 1'b0;
      end else if (step) begin
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         recent_ff <= recent_in;
         smoke_ff  <= smoke_in;
         accum_ff  <= accum_in;
         bad_ff    <= bad_in;
      end
   end

   `AFD_ASSERT_NEXT(a_hunt_after_result, clock, reset, emit,
      mode_ff == MODE_HUNT, "parser not hunting after a result")
   `AFD_ASSERT_IMPLY(a_count_in_frame, clock, reset, mode_ff == MODE_FRAME,
      (count_ff >= CW'(2)) && (count_ff < CW'(MAX_FRAME)), "frame byte count out of range")
   `AFD_ASSERT_IMPLY(a_hunt_clean, clock, reset, mode_ff != MODE_FRAME,
      (count_ff == '0) && !smoke_ff && !bad_ff && (accum_ff == '0), "frame state left while hunting")

endmodule

`default_nettype wire

// ----- src/alarm_frame_deframer.sv -----
// data path: a request accepted into the input register is parsed from there, and the
// parser loads its result into the result register when it advances; rsp takes it from there
// throughput: one request per cycle; rsp_stall holds the result register and the
// input register, so the parser only advances when the result register can load
// reset: synchronous, active high; clears both valid flags and returns the parser
// to hunting with an empty byte history, ready on the next cycle
// top level of the alarm frame deframer: input register, parser, result register
// depends on afd_pkg and afd_parser
`timescale 1ns / 1ps
`default_nettype none

module alarm_frame_deframer #(
   parameter int MAX_FRAME = afd_pkg::MAX_FRAME_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_frame_kind,
   output logic [9:0]      rsp_point_number,
   output logic            rsp_point_valid
);

   logic                    in_valid_ff;
   logic [7:0]              in_byte_ff;
   logic                    rsp_valid_ff;
   afd_pkg::afd_result_type rsp_data_ff;

   logic                    out_ready;
   logic                    advance;
   logic                    emit;
   afd_pkg::afd_result_type result;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   afd_parser #(
      .MAX_FRAME (MAX_FRAME)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_kind   = rsp_data_ff.frame_kind;
   assign rsp_point_number = rsp_data_ff.point_number;
   assign rsp_point_valid  = rsp_data_ff.point_valid;

endmodule

`default_nettype wire

// ----- bench/alarm_frame_deframer_tb.sv -----
// self-checking bench for alarm_frame_deframer: directed byte table, then random frames
// predicts results with its own deframer model; depends on afd_pkg and the rtl top level
`timescale 1ns / 1ps

module alarm_frame_deframer_tb;

   localparam int FRAME_LIMIT = afd_pkg::MAX_FRAME_DEFAULT;
   localparam int ITEM_TARGET = 1650;
   localparam int HOLD_CYCLES = 400;

   localparam logic [1:0] MODE_HUNT  = 2'd0;
   localparam logic [1:0] MODE_FRAME = 2'd1;

   typedef struct {
      logic [7:0]              rx_byte;
      bit                      fixed;
      bit                      fixed_hit;
      afd_pkg::afd_result_type fixed_res;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_frame_kind;
   logic [9:0] rsp_point_number;
   logic       rsp_point_valid;

   // tag of the request on req, read when it is accepted
   bit                      cur_fixed = 1'b0;
   bit                      cur_hit = 1'b0;
   afd_pkg::afd_result_type cur_fres = '0;

   afd_pkg::afd_result_type frame_q[$];
   stim_row_type            dir_rows[$];
   int                      fail_count = 0;
   int                      sent_count = 0;
   int                      send_idle_pct = 33;
   int                      recv_idle_pct = 49;
   bit                      hold_go = 1'b0;

   // deframer state
   logic [1:0]  frm_mode = MODE_HUNT;
   int          frm_len = 0;
   logic [31:0] frm_hist = '0;
   logic        frm_smoke = 1'b0;
   int          frm_point = 0;
   logic        frm_bad = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   alarm_frame_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_kind   (rsp_frame_kind),
      .rsp_point_number (rsp_point_number),
      .rsp_point_valid  (rsp_point_valid)
   );

   function automatic void clear_frame();
      frm_mode  = MODE_HUNT;
      frm_len   = 0;
      frm_hist  = '0;
      frm_smoke = 1'b0;
      frm_point = 0;
      frm_bad   = 1'b0;
   endfunction

   function automatic void deframe_byte(input logic [7:0] b, output bit hit,
                                        output afd_pkg::afd_result_type res);
      int digit;
      bit ok;
      hit = 1'b0;
      res = '0;
      if (frm_mode != MODE_FRAME) begin
         if (frm_hist[7:0] == afd_pkg::START_FIRST && b == afd_pkg::CR_BYTE) begin
            frm_mode  = MODE_FRAME;
            frm_len   = 2;
            frm_hist  = {16'h0000, afd_pkg::START_FIRST, afd_pkg::CR_BYTE};
            frm_smoke = 1'b0;
            frm_point = 0;
            frm_bad   = 1'b0;
         end else begin
            frm_hist = {frm_hist[23:0], b};
         end
         return;
      end
      frm_hist = {frm_hist[23:0], b};
      if (frm_len >= 2 && frm_len <= 4) begin
         digit = 0;
         if (b >= afd_pkg::ASCII_ZERO && b <= afd_pkg::ASCII_NINE) begin
            digit = int'(b - afd_pkg::ASCII_ZERO);
         end else begin
            frm_bad = 1'b1;
         end
         frm_point = (frm_point * 10 + digit) & 32'h3FF;
      end
      frm_len++;
      if (frm_hist == afd_pkg::SMOKE_MARK) begin
         frm_smoke = 1'b1;
      end
      if (frm_len > 2 && frm_hist[15:0] == afd_pkg::END_PAIR) begin
         ok = !frm_bad && frm_len >= 5;
         hit = 1'b1;
         res.frame_kind   = frm_smoke ? afd_pkg::KIND_SMOKE : afd_pkg::KIND_NORMAL;
         res.point_number = ok ? frm_point[9:0] : 10'd0;
         res.point_valid  = ok;
         clear_frame();
      end else if (frm_len >= FRAME_LIMIT) begin
         hit = 1'b1;
         res.frame_kind = afd_pkg::KIND_OVERFLOW;
         clear_frame();
      end
   endfunction

   function automatic void add_row(input logic [7:0] b, input bit fixed = 1'b0,
                                   input bit fhit = 1'b0,
                                   input logic [1:0] kind = afd_pkg::KIND_NORMAL,
                                   input logic [9:0] num = 10'd0, input logic pv = 1'b0);
      stim_row_type row;
      row.rx_byte   = b;
      row.fixed     = fixed;
      row.fixed_hit = fhit;
      row.fixed_res.frame_kind   = kind;
      row.fixed_res.point_number = num;
      row.fixed_res.point_valid  = pv;
      dir_rows = {dir_rows, row};
   endfunction

   task automatic note_fail(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input bit fixed = 1'b0, input bit fhit = 1'b0,
                            input afd_pkg::afd_result_type fres = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      cur_fixed   <= fixed;
      cur_hit     <= fhit;
      cur_fres    <= fres;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      if (sent_count == 300) begin
         hold_go <= 1'b1;
      end
      if (sent_count < 550) begin
         send_idle_pct = 33;
         recv_idle_pct <= 49;
      end else if (sent_count < 1100) begin
         send_idle_pct = 49;
         recv_idle_pct <= 33;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct <= 0;
      end
   endtask

   // result receiver with one long hold-off
   always @(posedge clock) begin : receiver
      int  hold_left;
      bit  hold_done;
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : scoreboard
      bit                      hit;
      afd_pkg::afd_result_type res;
      afd_pkg::afd_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte, hit, res);
            if (cur_fixed) begin
               if (cur_hit) frame_q = {frame_q, cur_fres};
            end else if (hit) begin
               frame_q = {frame_q, res};
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (frame_q.size() == 0) begin
               note_fail($sformatf("unexpected result: kind %0d point %0d valid %0d",
                                   rsp_frame_kind, rsp_point_number, rsp_point_valid));
            end else begin
               want = frame_q.pop_front();
               if (want.frame_kind !== rsp_frame_kind)
                  note_fail($sformatf("frame_kind: expected %0d, got %0d",
                                      want.frame_kind, rsp_frame_kind));
               if (want.point_number !== rsp_point_number)
                  note_fail($sformatf("point_number: expected %0d, got %0d",
                                      want.point_number, rsp_point_number));
               if (want.point_valid !== rsp_point_valid)
                  note_fail($sformatf("point_valid: expected %0d, got %0d",
                                      want.point_valid, rsp_point_valid));
            end
         end
      end
   end

   initial begin : stimulus
      logic [7:0] seq[$];
      logic [7:0] b;
      int         r;
      int         n;
      int         cut;
      bit         overflow_done;
      bit         pause_done;
      clear_frame();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_row(8'h00, 1'b1);
      add_row(8'hFF, 1'b1);
      add_row(afd_pkg::CR_BYTE, 1'b1);
      add_row(afd_pkg::START_FIRST);
      add_row(afd_pkg::CR_BYTE);
      add_row(8'h39);
      add_row(8'h39);
      add_row(8'h39);
      add_row(afd_pkg::CR_BYTE);
      add_row(afd_pkg::CR_BYTE, 1'b1, 1'b1, afd_pkg::KIND_NORMAL, 10'd999, 1'b1);
      add_row(afd_pkg::START_FIRST);
      add_row(afd_pkg::CR_BYTE);
      add_row(afd_pkg::ASCII_ZERO);
      add_row(afd_pkg::ASCII_ZERO);
      add_row(afd_pkg::ASCII_ZERO);
      add_row(afd_pkg::SMOKE_MARK[31:24]);
      add_row(afd_pkg::SMOKE_MARK[23:16]);
      add_row(afd_pkg::SMOKE_MARK[15:8]);
      add_row(afd_pkg::SMOKE_MARK[7:0]);
      add_row(afd_pkg::CR_BYTE);
      add_row(afd_pkg::CR_BYTE, 1'b1, 1'b1, afd_pkg::KIND_SMOKE, 10'd0, 1'b1);
      // short frame, its first digit byte is the closing cr
      add_row(afd_pkg::START_FIRST);
      add_row(afd_pkg::CR_BYTE);
      add_row(afd_pkg::CR_BYTE, 1'b1, 1'b1, afd_pkg::KIND_NORMAL, 10'd0, 1'b0);
      // history is empty again after a frame
      add_row(afd_pkg::CR_BYTE, 1'b1);
      foreach (dir_rows[i]) begin
         send_byte(dir_rows[i].rx_byte, dir_rows[i].fixed, dir_rows[i].fixed_hit,
                   dir_rows[i].fixed_res);
      end

      overflow_done = 1'b0;
      pause_done = 1'b0;
      while (sent_count < ITEM_TARGET) begin
         seq.delete();
         if (!pause_done && sent_count >= 1450) begin
            pause_done = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (frame_q.size() != 0) @(posedge clock);
         end
         r = $urandom_range(99);
         if (!overflow_done && sent_count >= 500) begin
            overflow_done = 1'b1;
            seq = {seq, afd_pkg::START_FIRST};
            seq = {seq, afd_pkg::CR_BYTE};
            repeat (FRAME_LIMIT + 6) begin
               b = 8'($urandom_range(255));
               seq = {seq, (b == afd_pkg::CR_BYTE) ? 8'h0E : b};
            end
         end else if (r < 10) begin
            repeat ($urandom_range(4, 1)) begin
               case ($urandom_range(3))
                  0: seq = {seq, afd_pkg::START_FIRST};
                  1: seq = {seq, afd_pkg::CR_BYTE};
                  default: seq = {seq, 8'($urandom_range(255))};
               endcase
            end
         end else if (r < 16) begin
            seq = {seq, afd_pkg::START_FIRST};
            seq = {seq, 8'($urandom_range(255))};
         end else begin
            seq = {seq, afd_pkg::START_FIRST};
            seq = {seq, afd_pkg::CR_BYTE};
            cut = ($urandom_range(9) == 0) ? $urandom_range(2) : 3;
            for (int i = 0; i < cut; i++) begin
               if ($urandom_range(99) < 85)
                  seq = {seq, 8'(afd_pkg::ASCII_ZERO + $urandom_range(9))};
               else
                  seq = {seq, 8'($urandom_range(255))};
            end
            if (cut == 3) begin
               n = $urandom_range(12);
               repeat (n) seq = {seq, 8'($urandom_range(255))};
               if ($urandom_range(3) == 0) begin
                  seq = {seq, afd_pkg::SMOKE_MARK[31:24]};
                  seq = {seq, afd_pkg::SMOKE_MARK[23:16]};
                  seq = {seq, afd_pkg::SMOKE_MARK[15:8]};
                  seq = {seq, afd_pkg::SMOKE_MARK[7:0]};
                  repeat ($urandom_range(3)) seq = {seq, 8'($urandom_range(255))};
               end
            end
            seq = {seq, afd_pkg::CR_BYTE};
            seq = {seq, afd_pkg::CR_BYTE};
         end
         foreach (seq[i]) send_byte(seq[i]);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
